/* hw/rtl/prs_pkg.sv */
// Shared types, register map and reset constants for the paired relay timed sequencer.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
`default_nettype none

package prs_pkg;

   // Width of every configuration register and of the write data port.
   localparam int REG_BITS = 20;
   // Default width of the tick counters.
   localparam int TIMER_BITS_DEFAULT = 20;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [REG_BITS-1:0] SWITCH_ON_DELAY_RESET  = 20'd3000;
   localparam logic [REG_BITS-1:0] RELAY_RUN_LIMIT_RESET  = 20'd905000;
   localparam logic [REG_BITS-1:0] SWITCH_RUN_LIMIT_RESET = 20'd900000;
   localparam logic [REG_BITS-1:0] BUZZ_LENGTH_RESET      = 20'd1000;
   localparam logic [REG_BITS-1:0] RESET_DEBOUNCE_RESET   = 20'd50;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SWITCH_ON_DELAY  = 3'd0,
      CSR_RELAY_RUN_LIMIT  = 3'd1,
      CSR_SWITCH_RUN_LIMIT = 3'd2,
      CSR_BUZZ_LENGTH      = 3'd3,
      CSR_RESET_DEBOUNCE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [REG_BITS-1:0] switch_on_delay;
      logic [REG_BITS-1:0] relay_run_limit;
      logic [REG_BITS-1:0] switch_run_limit;
      logic [REG_BITS-1:0] buzz_length;
      logic [REG_BITS-1:0] reset_debounce;
   } cfg_type;

   typedef struct packed {
      logic       tick;
      logic [3:0] button_levels;
      logic       reset_level;
      logic       remote_valid;
      logic [1:0] remote_zone;
      logic       remote_value;
      logic       remote_reset;
   } req_type;

   typedef struct packed {
      logic [3:0] relay_outputs;
      logic       switch_output;
      logic       buzzer_output;
   } rsp_type;

   // Relay pair of each zone: bit i is relay i+1.
   function automatic logic [3:0] pair_mask(input logic [1:0] zone);
      logic [3:0] mask;
      unique case (zone)
         2'd0: mask = 4'b0101;
         2'd1: mask = 4'b1001;
         2'd2: mask = 4'b0110;
         2'd3: mask = 4'b1010;
         default: mask = 4'b0000;
      endcase
      return mask;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/paired_relay_timed_sequencer_core.sv */
// A request is held in the input register, its result in the result register behind it.
// Throughput: one item per cycle unless stalled; one pass of logic between the registers.
// A full, stalled result register holds a full input register and raises req_stall.
// Reset (synchronous, active high) empties both registers, restores the register defaults
// and clears relays, switch, timers, buzzer and debounce; button history reads released.
// Top level of the paired relay timed sequencer; uses prs_pkg, prs_csr and prs_engine.
`default_nettype none

module paired_relay_timed_sequencer_core #(
   parameter int TIMER_BITS = prs_pkg::TIMER_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire prs_pkg::req_type                    req_data,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output prs_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [prs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [prs_pkg::REG_BITS-1:0]       csr_wdata
);

   prs_pkg::cfg_type cfg;
   prs_pkg::rsp_type result;

   logic             in_valid_ff, in_valid_in;
   prs_pkg::req_type in_data_ff;
   logic             out_valid_ff, out_valid_in;
   prs_pkg::rsp_type out_data_ff;
   logic             fire;

   // Process the held item when the result register is free or draining.
   assign fire        = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !fire;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = fire ? 1'b1 : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   prs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   prs_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/prs_csr.sv */
// Configuration register file of the paired relay timed sequencer.
// Depends on prs_pkg for the register map, widths and reset values.
`default_nettype none

module prs_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [prs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [prs_pkg::REG_BITS-1:0]       csr_wdata,
   output prs_pkg::cfg_type                         cfg
);

   prs_pkg::cfg_type cfg_ff;
   prs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         // indexes beyond the map are dropped
         unique case (csr_index)
            prs_pkg::CSR_SWITCH_ON_DELAY:  cfg_in.switch_on_delay  = csr_wdata;
            prs_pkg::CSR_RELAY_RUN_LIMIT:  cfg_in.relay_run_limit  = csr_wdata;
            prs_pkg::CSR_SWITCH_RUN_LIMIT: cfg_in.switch_run_limit = csr_wdata;
            prs_pkg::CSR_BUZZ_LENGTH:      cfg_in.buzz_length      = csr_wdata;
            prs_pkg::CSR_RESET_DEBOUNCE:   cfg_in.reset_debounce   = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.switch_on_delay  <= prs_pkg::SWITCH_ON_DELAY_RESET;
         cfg_ff.relay_run_limit  <= prs_pkg::RELAY_RUN_LIMIT_RESET;
         cfg_ff.switch_run_limit <= prs_pkg::SWITCH_RUN_LIMIT_RESET;
         cfg_ff.buzz_length      <= prs_pkg::BUZZ_LENGTH_RESET;
         cfg_ff.reset_debounce   <= prs_pkg::RESET_DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/prs_engine.sv */
// Relay, switch, timer, buzzer and debounce state with its single-pass update logic.
// Depends on prs_pkg for the item, result and configuration types.
`default_nettype none

module prs_engine #(
   parameter int TIMER_BITS = prs_pkg::TIMER_BITS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire prs_pkg::req_type item,
   input  wire prs_pkg::cfg_type cfg,
   output prs_pkg::rsp_type result
);

   localparam int CMP_BITS = (TIMER_BITS > prs_pkg::REG_BITS) ? TIMER_BITS : prs_pkg::REG_BITS;
   localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

   logic [3:0]            relay_states_ff, relay_states_in;
   logic                  switch_state_ff, switch_state_in;
   logic [3:0]            last_buttons_ff, last_buttons_in;
   logic                  last_reset_ff, last_reset_in;
   logic                  on_delay_active_ff, on_delay_active_in;
   logic [TIMER_BITS-1:0] on_delay_count_ff, on_delay_count_in;
   logic                  relay_timer_active_ff, relay_timer_active_in;
   logic [TIMER_BITS-1:0] relay_timer_count_ff, relay_timer_count_in;
   logic                  switch_timer_active_ff, switch_timer_active_in;
   logic [TIMER_BITS-1:0] switch_timer_count_ff, switch_timer_count_in;
   logic [TIMER_BITS-1:0] buzz_count_ff, buzz_count_in;
   logic                  debounce_pending_ff, debounce_pending_in;
   logic [TIMER_BITS-1:0] debounce_count_ff, debounce_count_in;

   logic [TIMER_BITS-1:0] buzz_load;
   logic [3:0]            mask;

   function automatic logic [TIMER_BITS-1:0] advance(input logic [TIMER_BITS-1:0] cnt);
      return (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
   endfunction

   function automatic logic reached(input logic [TIMER_BITS-1:0] cnt,
                                    input logic [prs_pkg::REG_BITS-1:0] limit);
      return CMP_BITS'(cnt) >= CMP_BITS'(limit);
   endfunction

   // Clamp the pulse length to what the counter holds.
   always_comb begin
      if (CMP_BITS'(cfg.buzz_length) > CMP_BITS'(CNT_MAX)) begin
         buzz_load = CNT_MAX;
      end else begin
         buzz_load = TIMER_BITS'(cfg.buzz_length);
      end
   end

   always_comb begin
      relay_states_in        = relay_states_ff;
      switch_state_in        = switch_state_ff;
      on_delay_active_in     = on_delay_active_ff;
      on_delay_count_in      = on_delay_count_ff;
      relay_timer_active_in  = relay_timer_active_ff;
      relay_timer_count_in   = relay_timer_count_ff;
      switch_timer_active_in = switch_timer_active_ff;
      switch_timer_count_in  = switch_timer_count_ff;
      buzz_count_in          = buzz_count_ff;
      debounce_pending_in    = debounce_pending_ff;
      debounce_count_in      = debounce_count_ff;
      mask                   = prs_pkg::pair_mask(item.remote_zone);

      if (item.tick) begin
         if (on_delay_active_ff)     on_delay_count_in     = advance(on_delay_count_ff);
         if (relay_timer_active_ff)  relay_timer_count_in  = advance(relay_timer_count_ff);
         if (switch_timer_active_ff) switch_timer_count_in = advance(switch_timer_count_ff);
         if (debounce_pending_ff)    debounce_count_in     = advance(debounce_count_ff);
         if (buzz_count_ff != '0)    buzz_count_in         = buzz_count_ff - 1'b1;
      end

      if (item.remote_valid) begin
         relay_states_in = item.remote_value ? (relay_states_in | mask)
                                             : (relay_states_in & ~mask);
         switch_state_in = item.remote_value;
         buzz_count_in   = buzz_load;
      end
      if (item.remote_reset) begin
         relay_states_in        = '0;
         switch_state_in        = 1'b0;
         on_delay_active_in     = 1'b0;
         relay_timer_active_in  = 1'b0;
         switch_timer_active_in = 1'b0;
      end

      // Falling edges in zone order; each sees the pair state left by the one before.
      for (int i = 0; i < 4; i++) begin
         if (!item.button_levels[i] && last_buttons_ff[i]) begin
            mask            = prs_pkg::pair_mask(2'(i));
            relay_states_in = relay_states_in ^ mask;
            buzz_count_in   = buzz_load;
            if ((relay_states_in & mask) == mask) begin
               relay_timer_active_in = 1'b1;
               relay_timer_count_in  = '0;
               on_delay_active_in    = 1'b1;
               on_delay_count_in     = '0;
            end else begin
               switch_state_in = 1'b0;
            end
         end
      end

      if (!item.reset_level && last_reset_ff) begin
         debounce_pending_in = 1'b1;
         debounce_count_in   = '0;
      end else if (item.reset_level) begin
         debounce_pending_in = 1'b0;
      end
      if (debounce_pending_in && reached(debounce_count_in, cfg.reset_debounce)) begin
         debounce_pending_in    = 1'b0;
         relay_states_in        = '0;
         switch_state_in        = 1'b0;
         on_delay_active_in     = 1'b0;
         relay_timer_active_in  = 1'b0;
         switch_timer_active_in = 1'b0;
      end

      if (on_delay_active_in && reached(on_delay_count_in, cfg.switch_on_delay)) begin
         switch_state_in        = 1'b1;
         switch_timer_active_in = 1'b1;
         switch_timer_count_in  = '0;
         on_delay_active_in     = 1'b0;
      end
      if (relay_timer_active_in && reached(relay_timer_count_in, cfg.relay_run_limit)) begin
         relay_states_in       = '0;
         relay_timer_active_in = 1'b0;
         buzz_count_in         = buzz_load;
      end
      if (switch_timer_active_in && reached(switch_timer_count_in, cfg.switch_run_limit)) begin
         switch_state_in        = 1'b0;
         switch_timer_active_in = 1'b0;
      end
   end

   assign last_buttons_in = item.button_levels;
   assign last_reset_in   = item.reset_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_states_ff        <= '0;
         switch_state_ff        <= 1'b0;
         last_buttons_ff        <= '1;
         last_reset_ff          <= 1'b1;
         on_delay_active_ff     <= 1'b0;
         on_delay_count_ff      <= '0;
         relay_timer_active_ff  <= 1'b0;
         relay_timer_count_ff   <= '0;
         switch_timer_active_ff <= 1'b0;
         switch_timer_count_ff  <= '0;
         buzz_count_ff          <= '0;
         debounce_pending_ff    <= 1'b0;
         debounce_count_ff      <= '0;
      end else if (fire) begin
         relay_states_ff        <= relay_states_in;
         switch_state_ff        <= switch_state_in;
         last_buttons_ff        <= last_buttons_in;
         last_reset_ff          <= last_reset_in;
         on_delay_active_ff     <= on_delay_active_in;
         on_delay_count_ff      <= on_delay_count_in;
         relay_timer_active_ff  <= relay_timer_active_in;
         relay_timer_count_ff   <= relay_timer_count_in;
         switch_timer_active_ff <= switch_timer_active_in;
         switch_timer_count_ff  <= switch_timer_count_in;
         buzz_count_ff          <= buzz_count_in;
         debounce_pending_ff    <= debounce_pending_in;
         debounce_count_ff      <= debounce_count_in;
      end
   end

   // Result is the state after the item.
   assign result.relay_outputs = relay_states_in;
   assign result.switch_output = switch_state_in;
   assign result.buzzer_output = (buzz_count_in != '0);

endmodule

`default_nettype wire

/* tb/sv/tb_paired_relay_timed_sequencer_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for paired_relay_timed_sequencer_core: a directed table, then
// random button, reset-button and remote traffic under several register settings.
// Depends on prs_pkg and the core RTL; responses not fixed by the table are predicted in-line.
module tb_paired_relay_timed_sequencer_core;

   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int PHASES           = 8;
   localparam int RANDOM_PER_PHASE = 244;
   localparam int DIRECTED_ROWS    = 23;
   localparam int REQ_BITS         = $bits(prs_pkg::req_type);
   localparam logic [19:0] CNT_TOP = 20'hFFFFF;
   localparam logic [19:0] REG_TOP = 20'hFFFFF;

   // Relays toggled by each zone, bit i is relay i+1.
   localparam logic [3:0] ZONE_RELAYS [4] = '{4'b0101, 4'b1001, 4'b0110, 4'b1010};

   // Row layout: {fixed, tick, buttons, reset_level, remote_valid, zone, value, remote_reset,
   //              relays, switch, buzzer}; the response is used only where fixed is set.
   localparam logic [17:0] DIRECTED [DIRECTED_ROWS] = '{
      {1'b1, 1'b0, 4'b1111, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 4'b0000, 1'b0, 1'b0},
      {1'b0, 1'b0, 4'b1110, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b1, 4'b1110, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b1, 4'b1111, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b1, 4'b1111, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b0, 4'b1001, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b1, 4'b1111, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b0, 4'b0000, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b1, 4'b1111, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b1, 1'b0, 4'b1111, 1'b1, 1'b1, 2'd3, 1'b1, 1'b1, 4'b0000, 1'b0, 1'b1},
      {1'b0, 1'b0, 4'b1111, 1'b1, 1'b1, 2'd2, 1'b1, 1'b0, 6'b0},
      {1'b0, 1'b1, 4'b1111, 1'b1, 1'b1, 2'd1, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b0, 4'b1111, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b1, 4'b1111, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b1, 4'b1111, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b1, 4'b0111, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b1, 4'b0111, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b1, 4'b1111, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b0, 4'b0111, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b0, 1'b1, 4'b1111, 1'b1, 1'b0, 2'd0, 1'b0, 1'b1, 6'b0},
      {1'b0, 1'b1, 4'b1111, 1'b1, 1'b0, 2'd0, 1'b0, 1'b0, 6'b0},
      {1'b1, 1'b1, 4'b1111, 1'b1, 1'b1, 2'd3, 1'b1, 1'b1, 4'b0000, 1'b0, 1'b1},
      {1'b1, 1'b0, 4'b0000, 1'b0, 1'b0, 2'd0, 1'b0, 1'b0, 4'b0000, 1'b0, 1'b1}
   };

   typedef struct {
      bit               fixed;
      prs_pkg::rsp_type rsp;
   } row_tag_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   prs_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   prs_pkg::rsp_type rsp_data;
   logic csr_we;
   logic [prs_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [prs_pkg::REG_BITS-1:0] csr_wdata;

   paired_relay_timed_sequencer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the sequencer state and registers.
   prs_pkg::cfg_type cfg_shadow;
   logic [3:0]  relay_q;
   logic        switch_q;
   logic [3:0]  last_btn_q;
   logic        last_rlevel_q;
   logic        delay_on_q;
   logic [19:0] delay_cnt_q;
   logic        run_on_q;
   logic [19:0] run_cnt_q;
   logic        sw_run_on_q;
   logic [19:0] sw_run_cnt_q;
   logic [19:0] buzz_cnt_q;
   logic        db_armed_q;
   logic [19:0] db_cnt_q;

   prs_pkg::rsp_type rsp_expected_q [$];
   row_tag_type fixed_rsp_q [$];
   int fail_count = 0;
   int cycle_count = 0;
   int quiet_cycles = 0;
   logic [3:0] btn_now;
   logic rst_now;
   logic calm;

   // No random idling on either side inside this window.
   assign calm = (cycle_count >= 1500) && (cycle_count < 2300);

   function automatic prs_pkg::cfg_type mk_cfg(input logic [19:0] on_delay, input logic [19:0] run,
                                               input logic [19:0] sw_run, input logic [19:0] buzz,
                                               input logic [19:0] debounce);
      prs_pkg::cfg_type c;
      c.switch_on_delay  = on_delay;
      c.relay_run_limit  = run;
      c.switch_run_limit = sw_run;
      c.buzz_length      = buzz;
      c.reset_debounce   = debounce;
      return c;
   endfunction

   function automatic logic [19:0] bump(input logic [19:0] c);
      return (c == CNT_TOP) ? c : c + 20'd1;
   endfunction

   function automatic void drop_outputs();
      relay_q     = 4'b0000;
      switch_q    = 1'b0;
      delay_on_q  = 1'b0;
      run_on_q    = 1'b0;
      sw_run_on_q = 1'b0;
   endfunction

   function automatic void reset_shadow();
      cfg_shadow = mk_cfg(prs_pkg::SWITCH_ON_DELAY_RESET, prs_pkg::RELAY_RUN_LIMIT_RESET,
                          prs_pkg::SWITCH_RUN_LIMIT_RESET, prs_pkg::BUZZ_LENGTH_RESET,
                          prs_pkg::RESET_DEBOUNCE_RESET);
      drop_outputs();
      last_btn_q    = 4'hF;
      last_rlevel_q = 1'b1;
      delay_cnt_q   = '0;
      run_cnt_q     = '0;
      sw_run_cnt_q  = '0;
      buzz_cnt_q    = '0;
      db_armed_q    = 1'b0;
      db_cnt_q      = '0;
   endfunction

   function automatic prs_pkg::rsp_type relay_seq_step(input prs_pkg::req_type r);
      prs_pkg::rsp_type o;
      logic [3:0] m;
      if (r.tick) begin
         if (delay_on_q) delay_cnt_q = bump(delay_cnt_q);
         if (run_on_q) run_cnt_q = bump(run_cnt_q);
         if (sw_run_on_q) sw_run_cnt_q = bump(sw_run_cnt_q);
         if (db_armed_q) db_cnt_q = bump(db_cnt_q);
         if (buzz_cnt_q != 0) buzz_cnt_q = buzz_cnt_q - 20'd1;
      end
      // Remote command first, then the remote reset on top of it.
      if (r.remote_valid) begin
         m = ZONE_RELAYS[r.remote_zone];
         relay_q = r.remote_value ? (relay_q | m) : (relay_q & ~m);
         switch_q = r.remote_value;
         buzz_cnt_q = cfg_shadow.buzz_length;
      end
      if (r.remote_reset) drop_outputs();
      for (int i = 0; i < 4; i++) begin
         if (!r.button_levels[i] && last_btn_q[i]) begin
            m = ZONE_RELAYS[i];
            relay_q = relay_q ^ m;
            buzz_cnt_q = cfg_shadow.buzz_length;
            if ((relay_q & m) == m) begin
               run_on_q    = 1'b1;
               run_cnt_q   = '0;
               delay_on_q  = 1'b1;
               delay_cnt_q = '0;
            end else begin
               switch_q = 1'b0;
            end
         end
      end
      last_btn_q = r.button_levels;
      if (!r.reset_level && last_rlevel_q) begin
         db_armed_q = 1'b1;
         db_cnt_q   = '0;
      end else if (r.reset_level) begin
         db_armed_q = 1'b0;
      end
      if (db_armed_q && db_cnt_q >= cfg_shadow.reset_debounce) begin
         db_armed_q = 1'b0;
         drop_outputs();
      end
      last_rlevel_q = r.reset_level;
      if (delay_on_q && delay_cnt_q >= cfg_shadow.switch_on_delay) begin
         switch_q     = 1'b1;
         sw_run_on_q  = 1'b1;
         sw_run_cnt_q = '0;
         delay_on_q   = 1'b0;
      end
      if (run_on_q && run_cnt_q >= cfg_shadow.relay_run_limit) begin
         relay_q    = 4'b0000;
         run_on_q   = 1'b0;
         buzz_cnt_q = cfg_shadow.buzz_length;
      end
      if (sw_run_on_q && sw_run_cnt_q >= cfg_shadow.switch_run_limit) begin
         switch_q    = 1'b0;
         sw_run_on_q = 1'b0;
      end
      o.relay_outputs = relay_q;
      o.switch_output = switch_q;
      o.buzzer_output = (buzz_cnt_q != 0);
      return o;
   endfunction

   // Mostly held button and reset levels with occasional edges, plus some noise.
   function automatic prs_pkg::req_type next_random_req();
      prs_pkg::req_type r;
      if ($urandom_range(0, 99) < 5) begin
         r = REQ_BITS'($urandom);
         btn_now = r.button_levels;
         rst_now = r.reset_level;
      end else begin
         for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 99) < 15) btn_now[i] = ~btn_now[i];
         end
         if (rst_now) rst_now = ($urandom_range(0, 99) >= 4);
         else rst_now = ($urandom_range(0, 99) < 12);
         r.tick          = ($urandom_range(0, 99) < 60);
         r.button_levels = btn_now;
         r.reset_level   = rst_now;
         r.remote_valid  = ($urandom_range(0, 99) < 6);
         r.remote_zone   = 2'($urandom_range(0, 3));
         r.remote_value  = 1'($urandom_range(0, 1));
         r.remote_reset  = ($urandom_range(0, 99) < 2);
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [3:0] want,
                                       input logic [3:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endfunction

   // Track registers and predict each accepted request.
   always @(posedge clock) begin
      row_tag_type tag;
      prs_pkg::rsp_type predicted;
      if (reset) begin
         reset_shadow();
         rsp_expected_q.delete();
      end else begin
         if (csr_we) begin
            unique case (prs_pkg::csr_index_type'(csr_index))
               prs_pkg::CSR_SWITCH_ON_DELAY:  cfg_shadow.switch_on_delay  = csr_wdata;
               prs_pkg::CSR_RELAY_RUN_LIMIT:  cfg_shadow.relay_run_limit  = csr_wdata;
               prs_pkg::CSR_SWITCH_RUN_LIMIT: cfg_shadow.switch_run_limit = csr_wdata;
               prs_pkg::CSR_BUZZ_LENGTH:      cfg_shadow.buzz_length      = csr_wdata;
               prs_pkg::CSR_RESET_DEBOUNCE:   cfg_shadow.reset_debounce   = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predicted = relay_seq_step(req_data);
            tag = fixed_rsp_q.pop_front();
            rsp_expected_q.push_back(tag.fixed ? tag.rsp : predicted);
         end
      end
   end

   always @(posedge clock) begin
      prs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expected_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
         end else begin
            want = rsp_expected_q.pop_front();
            check_field("relay_outputs", want.relay_outputs, rsp_data.relay_outputs);
            check_field("switch_output", want.switch_output, rsp_data.switch_output);
            check_field("buzzer_output", want.buzzer_output, rsp_data.buzzer_output);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !calm && ($urandom_range(0, 99) < 26);
   end

   // End the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("paired_relay_timed_sequencer_core verification failed");
            $finish;
         end
      end
   end

   task automatic send_req(input prs_pkg::req_type item, input bit fixed,
                           input prs_pkg::rsp_type fixed_rsp);
      row_tag_type tag;
      while (!calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      tag.fixed = fixed;
      tag.rsp   = fixed_rsp;
      fixed_rsp_q.push_back(tag);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      // Hold the payload until the transfer.
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_cfg(input prs_pkg::cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= prs_pkg::CSR_SWITCH_ON_DELAY;
      csr_wdata <= c.switch_on_delay;
      @(posedge clock);
      csr_index <= prs_pkg::CSR_RELAY_RUN_LIMIT;
      csr_wdata <= c.relay_run_limit;
      @(posedge clock);
      csr_index <= prs_pkg::CSR_SWITCH_RUN_LIMIT;
      csr_wdata <= c.switch_run_limit;
      @(posedge clock);
      csr_index <= prs_pkg::CSR_BUZZ_LENGTH;
      csr_wdata <= c.buzz_length;
      @(posedge clock);
      csr_index <= prs_pkg::CSR_RESET_DEBOUNCE;
      csr_wdata <= c.reset_debounce;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      prs_pkg::cfg_type phase_cfg [PHASES];
      logic [17:0] row;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      btn_now   = 4'hF;
      rst_now   = 1'b1;
      phase_cfg[0] = mk_cfg(20'd3, 20'd8, 20'd5, 20'd4, 20'd2);
      phase_cfg[1] = mk_cfg(20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
      phase_cfg[2] = mk_cfg(20'd1, 20'd12, 20'd0, 20'd1, 20'd3);
      phase_cfg[3] = mk_cfg(REG_TOP, REG_TOP, REG_TOP, REG_TOP, REG_TOP);
      phase_cfg[4] = mk_cfg(20'd6, 20'd20, 20'd4, 20'd0, 20'd1);
      phase_cfg[5] = mk_cfg(20'($urandom_range(0, 15)), 20'($urandom_range(0, 15)),
                            20'($urandom_range(0, 15)), 20'($urandom_range(0, 15)),
                            20'($urandom_range(0, 15)));
      phase_cfg[6] = mk_cfg(prs_pkg::SWITCH_ON_DELAY_RESET, prs_pkg::RELAY_RUN_LIMIT_RESET,
                            prs_pkg::SWITCH_RUN_LIMIT_RESET, prs_pkg::BUZZ_LENGTH_RESET,
                            prs_pkg::RESET_DEBOUNCE_RESET);
      phase_cfg[7] = mk_cfg(20'd2, 20'd3, 20'd9, 20'd7, 20'd5);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_cfg(mk_cfg(20'd0, 20'd3, 20'd2, 20'd2, 20'd0));
      for (int k = 0; k < DIRECTED_ROWS; k++) begin
         row = DIRECTED[k];
         send_req(row[16:6], row[17], row[5:0]);
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         write_cfg(phase_cfg[p]);
         repeat (RANDOM_PER_PHASE) send_req(next_random_req(), 1'b0, '0);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && rsp_expected_q.size() == 0) begin
         $display("paired_relay_timed_sequencer_core verification clean");
      end else begin
         $display("paired_relay_timed_sequencer_core verification failed");
      end
      $finish;
   end

endmodule

/* paired_relay_timed_sequencer_core.f */
hw/rtl/prs_pkg.sv
hw/rtl/prs_csr.sv
hw/rtl/prs_engine.sv
hw/rtl/paired_relay_timed_sequencer_core.sv
tb/sv/tb_paired_relay_timed_sequencer_core.sv
